[src/wmf_pkg.sv]
// Package for the window mean/median filter: pixel types, register
// indexes, command codes, cell control struct and sequencer states.
// No dependencies.
package wmf_pkg;

    localparam int CH_N      = 3;   // red, green, blue
    localparam int CH_W      = 8;
    localparam int PIX_W     = CH_N * CH_W;
    localparam int CFG_DIM_W = 11;  // width of the config write data
    localparam int SIDE_W    = 4;   // window side register width
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIAN = 2'd3;

    // Reset values of the registers
    localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = 11'd480;
    localparam logic [SIDE_W-1:0]    RST_WINDOW = 4'd3;

    // Request kinds carried on s_tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // One pixel, channel 0 (red) in the lowest byte
    typedef logic [CH_N-1:0][CH_W-1:0] pix_t;

    // Broadcast control to the sorting cells
    typedef struct packed {
        logic clear;  // empty all cells
        logic shift;  // move held values one cell toward cell 0
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_GATHER,
        ST_SETTLE,
        ST_EXTRACT,
        ST_FINISH
    } wmf_state_t;

endpackage

[src/wmf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/wmf_cell.sv]
// One cell of the systolic insertion sorter: keeps the smallest value seen
// per channel and hands the larger one to its right neighbor.
// Depends on wmf_pkg.
module wmf_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  wmf_pkg::cell_ctrl_t ctrl,
    input  logic               in_valid,
    input  wmf_pkg::pix_t      in_pix,
    input  wmf_pkg::pix_t      right_pix,
    output logic               out_valid,
    output wmf_pkg::pix_t      out_pix,
    output wmf_pkg::pix_t      held_pix
);
    import wmf_pkg::*;

    logic full_reg, full_next;
    logic valid_reg, valid_next;
    pix_t held_reg, held_next;
    pix_t pass_reg, pass_next;

    // Insert, shift or clear
    always_comb begin
        full_next  = full_reg;
        valid_next = 1'b0;
        held_next  = held_reg;
        pass_next  = pass_reg;
        if (ctrl.clear) begin
            full_next = 1'b0;
        end else if (ctrl.shift) begin
            held_next = right_pix;
        end else if (in_valid) begin
            if (!full_reg) begin
                held_next = in_pix;
                full_next = 1'b1;
            end else begin
                valid_next = 1'b1;
                for (int c = 0; c < CH_N; c++) begin
                    if (in_pix[c] < held_reg[c]) begin
                        held_next[c] = in_pix[c];
                        pass_next[c] = held_reg[c];
                    end else begin
                        pass_next[c] = in_pix[c];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            full_reg  <= full_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        pass_reg <= pass_next;
    end

    assign out_valid = valid_reg;
    assign out_pix   = pass_reg;
    assign held_pix  = held_reg;

endmodule

[src/wmf_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module wmf_divider #(
    parameter int NUM_W = 15,
    parameter int DEN_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             qbit;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            // shift in the next dividend bit and try a subtract
            rem_next = qbit ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            quo_next = {quo_reg[NUM_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[src/window_mean_median_filter.sv]
// Top level of the window mean/median filter: line store, window sequencer,
// sorting cell chain and mean dividers.
// Depends on wmf_pkg, wmf_ram, wmf_cell, wmf_divider.
//
//  channel | signals                         | use
//  --------+---------------------------------+------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser | pixel or drain request in
//  m_      | m_tvalid m_tready m_tdata m_tlast | filtered pixel out
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data | register writes
//
// One request is taken at a time. For one that makes an output ready, with
// count being the clipped window size (up to 81), the pixels are read one a
// cycle from the line store and pushed through the sorting cell chain, which
// settles and is then shifted out up to the median while the 15-bit mean
// dividers finish. A finished output waits in the output register; the next
// request is accepted meanwhile. Reset is synchronous, active low; the line
// store is not cleared, as no pixel is read before it is written.
module window_mean_median_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 9
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wmf_pkg::PIX_W-1:0]        s_tdata,   // red_in, green_in, blue_in
    input  logic                             s_tuser,   // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wmf_pkg::PIX_W-1:0]        m_tdata,   // red_out, green_out, blue_out
    output logic                             m_tlast,   // last_pixel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wmf_pkg::CFG_DIM_W-1:0]    cfg_data
);
    import wmf_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int AW    = $clog2((MAX_WINDOW + 1) * MAX_WIDTH);
    localparam int DEPTH = 2 ** AW;
    localparam int NCELL = MAX_WINDOW * MAX_WINDOW;
    localparam int CNT_W = $clog2(NCELL + 1);
    localparam int SUM_W = $clog2(NCELL * (2 ** CH_W - 1) + 1);
    localparam int DIM_W = SIDE_W + 1;

    wmf_state_t state_reg, state_next;

    // Registers
    logic [CFG_DIM_W-1:0] width_raw_reg, height_raw_reg;
    logic [SIDE_W-1:0]    side_raw_reg;
    logic                 median_reg;

    // Effective frame settings
    logic [WW-1:0]     w_eff, w_last;
    logic [HW-1:0]     h_eff, h_last;
    logic [SIDE_W-1:0] side, lead, after;

    always_comb begin
        if (width_raw_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_raw_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_raw_reg);
        end
        if (height_raw_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_raw_reg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_raw_reg);
        end
        if (side_raw_reg < SIDE_W'(2)) begin
            side = SIDE_W'(1);
        end else if (32'(side_raw_reg) > MAX_WINDOW) begin
            side = SIDE_W'(MAX_WINDOW);
        end else begin
            side = side_raw_reg;
        end
        w_last = w_eff - 1'b1;
        h_last = h_eff - 1'b1;
        lead   = side >> 1;
        after  = side - 1'b1 - lead;
    end

    // Input and output raster positions
    logic [HW-1:0] in_row_reg, out_row_reg;
    logic [WW-1:0] in_col_reg, out_col_reg;
    logic [AW-1:0] wptr_reg, optr_reg;

    logic cfg_acc, s_acc, pix_acc, restart;
    logic [HW-1:0] row_b;
    logic [WW-1:0] col_b;
    logic [AW-1:0] ptr_b;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s_acc     = s_tvalid && s_tready;
    assign pix_acc   = s_acc && (s_tuser == CMD_PIXEL);

    // A pixel after a complete frame opens a new frame
    assign restart = (in_row_reg == h_eff);
    assign row_b   = restart ? '0 : in_row_reg;
    assign col_b   = restart ? '0 : in_col_reg;
    assign ptr_b   = restart ? '0 : wptr_reg;

    // Window bounds of the next output
    logic [HW:0]       r_far;
    logic [WW:0]       c_far;
    logic [HW-1:0]     r1;
    logic [WW-1:0]     c1;
    logic [SIDE_W-1:0] dr, dc;
    logic [DIM_W-1:0]  rows, cols;
    logic              ready_now;

    always_comb begin
        r_far = {1'b0, out_row_reg} + (HW+1)'(after);
        c_far = {1'b0, out_col_reg} + (WW+1)'(after);
        r1    = (r_far > {1'b0, h_last}) ? h_last : HW'(r_far);
        c1    = (c_far > {1'b0, w_last}) ? w_last : WW'(c_far);
        dr    = (out_row_reg >= HW'(lead)) ? lead : SIDE_W'(out_row_reg);
        dc    = (out_col_reg >= WW'(lead)) ? lead : SIDE_W'(out_col_reg);
        rows  = DIM_W'(r1 - out_row_reg) + {1'b0, dr} + 1'b1;
        cols  = DIM_W'(c1 - out_col_reg) + {1'b0, dc} + 1'b1;
        ready_now = (out_row_reg < h_eff) &&
                    ((r1 < in_row_reg) || ((r1 == in_row_reg) && (c1 < in_col_reg)));
    end

    // Job registers
    logic [SIDE_W-1:0] dr_reg, dc_reg;
    logic [DIM_W-1:0]  rows_reg, cols_reg, x_reg, y_reg;
    logic              last_reg;
    logic [AW-1:0]     base_reg;
    logic [CNT_W-1:0]  count_reg, k_reg, half;
    logic [CNT_W:0]    settle_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     raddr;
    logic [SIDE_W+WW-1:0] back;
    pix_t              rd_pix;
    logic [CH_N-1:0][SUM_W-1:0] sum_reg;
    pix_t              lo_reg, mid_reg;
    logic              gather_end;

    assign raddr      = base_reg + AW'(x_reg);
    assign back       = dr_reg * w_eff;
    assign half       = count_reg >> 1;
    assign gather_end = (x_reg == cols_reg - 1'b1) && (y_reg == rows_reg - 1'b1);

    // Line store
    wmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (pix_acc),
        .waddr (ptr_b),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rd_pix)
    );

    // Sorting cell chain
    cell_ctrl_t ctrl;
    logic [NCELL:0] chain_valid;
    pix_t           chain_pix  [NCELL+1];
    pix_t           held       [NCELL+1];

    assign chain_valid[0] = rd_valid_reg;
    assign chain_pix[0]   = rd_pix;
    assign held[NCELL]    = '0;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        wmf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .in_valid  (chain_valid[i]),
            .in_pix    (chain_pix[i]),
            .right_pix (held[i+1]),
            .out_valid (chain_valid[i+1]),
            .out_pix   (chain_pix[i+1]),
            .held_pix  (held[i])
        );
    end

    // Mean dividers, one per channel
    logic                       div_start;
    logic [CH_N-1:0]            div_done;
    logic [CH_N-1:0][SUM_W-1:0] quo;

    for (genvar c = 0; c < CH_N; c++) begin : g_div
        wmf_divider #(
            .NUM_W (SUM_W),
            .DEN_W (CNT_W)
        ) u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (div_start),
            .num     (sum_reg[c]),
            .den     (count_reg),
            .done    (div_done[c]),
            .quo     (quo[c])
        );
    end

    // Output register
    logic m_tvalid_reg;
    pix_t m_pix_reg, result;
    logic m_tlast_reg;
    logic load_out;
    logic [CH_W:0] pair_sum;

    always_comb begin
        result   = '0;
        pair_sum = '0;
        for (int c = 0; c < CH_N; c++) begin
            pair_sum = {1'b0, lo_reg[c]} + {1'b0, mid_reg[c]};
            if (median_reg) begin
                result[c] = count_reg[0] ? mid_reg[c] : pair_sum[CH_W:1];
            end else begin
                result[c] = quo[c][CH_W-1:0];
            end
        end
    end

    // Sequencer: next state and control strobes
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = ready_now ? ST_SETUP : ST_IDLE;
            end
            ST_SETUP: begin
                ctrl.clear = 1'b1;
                state_next = ST_GATHER;
            end
            ST_GATHER: begin
                if (gather_end) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                if (settle_reg == {1'b0, count_reg} + 1'b1) begin
                    div_start  = 1'b1;
                    state_next = ST_EXTRACT;
                end
            end
            ST_EXTRACT: begin
                ctrl.shift = (k_reg != half);
                if ((k_reg == half) && div_done[0]) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Registers and raster positions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_raw_reg  <= RST_WIDTH;
            height_raw_reg <= RST_HEIGHT;
            side_raw_reg   <= RST_WINDOW;
            median_reg     <= 1'b0;
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            wptr_reg       <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            optr_reg       <= '0;
        end else if (cfg_acc) begin
            unique case (cfg_index)
                REG_WIDTH:  width_raw_reg  <= cfg_data;
                REG_HEIGHT: height_raw_reg <= cfg_data;
                REG_WINDOW: side_raw_reg   <= cfg_data[SIDE_W-1:0];
                REG_MEDIAN: median_reg     <= cfg_data[0];
                default: ;
            endcase
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            wptr_reg    <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            optr_reg    <= '0;
        end else begin
            if (pix_acc) begin
                wptr_reg <= ptr_b + 1'b1;
                if ({1'b0, col_b} + 1'b1 == {1'b0, w_eff}) begin
                    in_col_reg <= '0;
                    in_row_reg <= row_b + 1'b1;
                end else begin
                    in_col_reg <= col_b + 1'b1;
                    in_row_reg <= row_b;
                end
                if (restart) begin
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                    optr_reg    <= '0;
                end
            end
            if (load_out) begin
                optr_reg <= optr_reg + 1'b1;
                if (out_col_reg == w_last) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 1'b1;
                end else begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    // Window job datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= (state_reg == ST_GATHER);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CHECK) begin
            dr_reg   <= dr;
            dc_reg   <= dc;
            rows_reg <= rows;
            cols_reg <= cols;
            last_reg <= (out_row_reg == h_last) && (out_col_reg == w_last);
        end
        if (state_reg == ST_SETUP) begin
            base_reg   <= optr_reg - AW'(back) - AW'(dc_reg);
            count_reg  <= CNT_W'(rows_reg * cols_reg);
            x_reg      <= '0;
            y_reg      <= '0;
            settle_reg <= '0;
            k_reg      <= '0;
            sum_reg    <= '0;
        end
        // walk the window row by row
        if (state_reg == ST_GATHER) begin
            if (x_reg == cols_reg - 1'b1) begin
                x_reg    <= '0;
                y_reg    <= y_reg + 1'b1;
                base_reg <= base_reg + AW'(w_eff);
            end else begin
                x_reg <= x_reg + 1'b1;
            end
        end
        if (rd_valid_reg) begin
            for (int c = 0; c < CH_N; c++) begin
                sum_reg[c] <= sum_reg[c] + SUM_W'(rd_pix[c]);
            end
        end
        if (state_reg == ST_SETTLE) begin
            settle_reg <= settle_reg + 1'b1;
        end
        // cell 0 shows the sorted values in ascending order
        if (state_reg == ST_EXTRACT) begin
            if (k_reg == half - 1'b1) begin
                lo_reg <= held[0];
            end
            if (k_reg == half) begin
                mid_reg <= held[0];
            end else begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_pix_reg   <= result;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[src/wmf_checker.sv]
// Port-level checks for the window mean/median filter, bound to the top.
// Depends on wmf_pkg and window_mean_median_filter.
module wmf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [wmf_pkg::PIX_W-1:0]     s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wmf_pkg::PIX_W-1:0]     m_tdata,
    input logic                          m_tlast,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);
    import wmf_pkg::*;

    // Output stalled: request holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output request changed while stalled");

    // Input waiting: request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input request changed while waiting");

    // One request at a time: not ready right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // Pixel side only open when idle and no register write is offered
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> cfg_ready && !cfg_valid)
        else $error("input ready while busy");

    // Nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind window_mean_median_filter wmf_checker u_wmf_checker (.*);

[tb/tb.sv]
// Self-checking testbench for window_mean_median_filter: random RGB frames
// of many sizes, window sides and both filter modes, with bursty idling.
// Depends on wmf_pkg and the filter RTL.
`timescale 1ns / 100ps

module tb;
    import wmf_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int MAX_H      = 1024;
    localparam int MAX_N      = 9;
    localparam int STORE_SIZE = (MAX_N + 1) * MAX_W;
    localparam int N_ITEMS    = 1300;
    localparam int SETTLE_CYC = 300;   // covers the slowest window pass

    typedef struct packed {
        logic cmd;
        pix_t pix;
    } pix_req_t;

    typedef struct packed {
        pix_t pix;
        logic last;
    } filt_pix_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [PIX_W-1:0] s_tdata = '0;
    logic s_tuser = CMD_PIXEL;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [PIX_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
    logic [CFG_DIM_W-1:0] cfg_data = '0;

    window_mean_median_filter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predictor state
    pix_t        pix_store [STORE_SIZE];
    int unsigned reg_w = RST_WIDTH, reg_h = RST_HEIGHT, reg_n = RST_WINDOW, reg_med = 0;
    int unsigned in_pos = 0, out_pos = 0;

    pix_req_t  pending_reqs[$];
    filt_pix_t expected_pix[$];
    int  errors = 0;
    int  mismatches = 0;
    bit  s_fire = 1'b0;
    bit  no_idle = 1'b0;
    int  s_gap = 0;
    int  m_gap = 0;

    function automatic int unsigned clip_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned side_eff();
        if (reg_n < 2) return 1;
        if (reg_n > MAX_N) return MAX_N;
        return reg_n;
    endfunction

    // Mean or median of one channel over the clipped window of position p
    function automatic logic [CH_W-1:0] filter_channel(int unsigned p, int ch);
        int unsigned w, h, n, bef, aft, r, c, r0, c0, r1, c1, cnt, sum, t, j;
        int unsigned vals [81];
        w = clip_dim(reg_w, MAX_W);
        h = clip_dim(reg_h, MAX_H);
        n = side_eff();
        bef = n / 2;
        aft = n - 1 - n / 2;
        r = p / w;
        c = p % w;
        r0 = (r >= bef) ? r - bef : 0;
        c0 = (c >= bef) ? c - bef : 0;
        r1 = (r + aft > h - 1) ? h - 1 : r + aft;
        c1 = (c + aft > w - 1) ? w - 1 : c + aft;
        cnt = 0;
        sum = 0;
        for (int unsigned y = r0; y <= r1; y++) begin
            for (int unsigned x = c0; x <= c1; x++) begin
                vals[cnt] = pix_store[(y * w + x) % STORE_SIZE][ch];
                sum += vals[cnt];
                cnt++;
            end
        end
        if (reg_med == 0) return CH_W'(sum / cnt);
        // insertion sort
        for (int unsigned i = 1; i < cnt; i++) begin
            t = vals[i];
            j = i;
            while (j > 0 && vals[j - 1] > t) begin
                vals[j] = vals[j - 1];
                j--;
            end
            vals[j] = t;
        end
        if (cnt % 2 == 1) return CH_W'(vals[cnt / 2]);
        return CH_W'((vals[cnt / 2 - 1] + vals[cnt / 2]) / 2);
    endfunction

    // Advance the filter state by one request, queue the output it releases
    function automatic void filter_request(pix_req_t req);
        int unsigned w, h, n, tot, aft, r, c, r1, c1;
        filt_pix_t res;
        w = clip_dim(reg_w, MAX_W);
        h = clip_dim(reg_h, MAX_H);
        n = side_eff();
        tot = w * h;
        aft = n - 1 - n / 2;
        if (req.cmd == CMD_PIXEL) begin
            if (in_pos >= tot) begin
                in_pos = 0;
                out_pos = 0;
            end
            pix_store[in_pos % STORE_SIZE] = req.pix;
            in_pos++;
        end
        if (out_pos < in_pos && out_pos < tot) begin
            r = out_pos / w;
            c = out_pos % w;
            r1 = (r + aft > h - 1) ? h - 1 : r + aft;
            c1 = (c + aft > w - 1) ? w - 1 : c + aft;
            if (r1 * w + c1 < in_pos) begin
                for (int ch = 0; ch < CH_N; ch++) res.pix[ch] = filter_channel(out_pos, ch);
                res.last = (out_pos == tot - 1);
                expected_pix.push_back(res);
                out_pos++;
            end
        end
    endfunction

    // Request side: track accepted requests and register writes
    always @(posedge aclk) begin
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            filter_request(pix_req_t'({s_tuser, s_tdata}));
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WIDTH:  reg_w = cfg_data;
                REG_HEIGHT: reg_h = cfg_data;
                REG_WINDOW: reg_n = cfg_data[SIDE_W-1:0];
                REG_MEDIAN: reg_med = cfg_data[0];
                default: ;
            endcase
            in_pos = 0;
            out_pos = 0;
        end
    end

    // Output side: compare against the oldest expected pixel
    always @(posedge aclk) begin
        filt_pix_t exp_p;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pix.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected output %h last %b", m_tdata, m_tlast);
            end else begin
                exp_p = expected_pix.pop_front();
                if (exp_p.pix != m_tdata || exp_p.last != m_tlast) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected %h last %b, got %h last %b",
                                 exp_p.pix, exp_p.last, m_tdata, m_tlast);
                end
            end
        end
    end

    // Request driver with random idle bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // hold until taken
        end else if (s_gap > 0) begin
            s_gap <= s_gap - 1;
            s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !no_idle && $urandom_range(0, 9) == 0) begin
            s_gap <= $urandom_range(0, 7);
            s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            pix_req_t req;
            req = pending_reqs.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= req.cmd;
            s_tdata <= req.pix;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Output backpressure in random bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            m_gap <= $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DIM_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic wait_idle();
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_pix.size() == 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    function automatic pix_t rand_pix();
        pix_t p;
        for (int ch = 0; ch < CH_N; ch++) begin
            case ($urandom_range(0, 7))
                0: p[ch] = 8'd0;
                1: p[ch] = 8'd255;
                default: p[ch] = 8'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    function automatic void push_pixel();
        pending_reqs.push_back('{cmd: CMD_PIXEL, pix: rand_pix()});
    endfunction

    function automatic void push_drain();
        pending_reqs.push_back('{cmd: CMD_DRAIN, pix: rand_pix()});
    endfunction

    // Stimulus: one frame per phase, registers rewritten in between
    initial begin
        int items, phase, w, h, n, med, tot, npix, order;
        logic [CFG_DIM_W-1:0] vals [4];
        items = 0;
        phase = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset setting: part of a 640 wide row, all zero and all max channels
        pending_reqs.push_back('{cmd: CMD_DRAIN, pix: '0});
        pending_reqs.push_back('{cmd: CMD_PIXEL, pix: '0});
        pending_reqs.push_back('{cmd: CMD_PIXEL, pix: '1});
        for (int i = 0; i < 6; i++) push_pixel();
        push_drain();
        items = 10;

        while (items < N_ITEMS) begin
            wait_idle();
            case (phase)
                0: begin
                    vals[0] = 11'd0;    vals[1] = 11'd0;    vals[2] = 11'd0;  vals[3] = 11'd0;
                end
                1: begin
                    vals[0] = 11'd2047; vals[1] = 11'd2;    vals[2] = 11'd9;  vals[3] = 11'd1;
                end
                2: begin
                    vals[0] = 11'd1;    vals[1] = 11'd7;    vals[2] = 11'd9;  vals[3] = 11'd1;
                end
                3: begin
                    vals[0] = 11'd5;    vals[1] = 11'd1;    vals[2] = 11'd2;  vals[3] = 11'd1;
                end
                4: begin
                    vals[0] = 11'd4;    vals[1] = 11'd2047; vals[2] = 11'd15; vals[3] = 11'd0;
                end
                5: begin
                    vals[0] = 11'd1024; vals[1] = 11'd1024; vals[2] = 11'd1;  vals[3] = 11'd0;
                end
                default: begin
                    w = $urandom_range(1, 16);
                    h = $urandom_range(1, 150 / w > 12 ? 12 : 150 / w);
                    n = $urandom_range(0, 15);
                    med = $urandom_range(0, 1);
                    vals[0] = CFG_DIM_W'(w);
                    vals[1] = CFG_DIM_W'(h);
                    // upper data bits are outside the register and must be ignored
                    vals[2] = {7'($urandom_range(0, 127)), 4'(n)};
                    vals[3] = {10'($urandom_range(0, 1023)), 1'(med)};
                end
            endcase
            order = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++)
                write_reg(CFG_IDX_W'((k + order) % 4), vals[(k + order) % 4]);
            @(negedge aclk);
            cfg_valid <= 1'b0;

            w = clip_dim(vals[0], MAX_W);
            h = clip_dim(vals[1], MAX_H);
            tot = w * h;
            npix = (tot > 40 && phase < 6) ? 40 : tot;
            // sometimes cut the frame short before the next register write
            if (phase >= 6 && $urandom_range(0, 5) == 0) npix = $urandom_range(1, tot);
            if (phase == 4) npix = 20;
            for (int i = 0; i < npix; i++) begin
                push_pixel();
                items++;
                if ($urandom_range(0, 4) == 0) begin
                    push_drain();
                    items++;
                end
                // hold the sender until the block has emptied once mid frame
                if (phase % 5 == 2 && i == npix / 2) begin
                    wait (pending_reqs.size() == 0 && !s_tvalid);
                    wait (expected_pix.size() == 0);
                end
            end
            for (int i = 0; i <= tot && i < npix + 2; i++) push_drain();
            items += npix + 2 < tot + 1 ? npix + 2 : tot + 1;
            // pixels past a complete frame start the next frame
            if (phase >= 6 && npix == tot && $urandom_range(0, 5) == 0) begin
                for (int i = 0; i < 3; i++) push_pixel();
                for (int i = 0; i < 3; i++) push_drain();
                items += 6;
            end
            if (items > N_ITEMS - 200) no_idle = 1'b1;
            phase++;
        end

        wait_idle();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(30_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

[window_mean_median_filter.f]
src/wmf_pkg.sv
src/wmf_ram.sv
src/wmf_cell.sv
src/wmf_divider.sv
src/window_mean_median_filter.sv
src/wmf_checker.sv
tb/tb.sv
